// File: hw/rtl/mwlfo_pkg.sv
// Package for the multi-wave low frequency oscillator.
// Holds the fixed-point formats, channel indexes, register addresses and sequencer states.
// No dependencies.
package mwlfo_pkg;

    localparam int F          = 16;
    localparam int W          = F + 2;
    localparam int WIDE_W     = W + 4;
    localparam int OPB_W      = W + 2;
    localparam int PROD_W     = W + OPB_W;
    localparam int MAX_CHUNK  = 24;
    localparam int LEN_W      = 5;
    localparam int NCH        = 5;
    localparam int CH_W       = 3;
    localparam int DIV_W      = W;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int STEP_W     = 16;
    localparam int SEED_W     = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;
    localparam int IN_TDATA_W = 8;
    localparam int NOUT       = 6;
    localparam int OUT_TDATA_W = ((NOUT * W + 7) / 8) * 8;

    typedef logic signed [W-1:0] t_val;

    localparam t_val VAL_ONE = t_val'(1 << F);
    localparam t_val VAL_MAX = t_val'((1 << (W - 1)) - 1);
    localparam t_val VAL_MIN = t_val'(1 << (W - 1));

    localparam logic [SEED_W-1:0] LFSR_MASK = 32'h8020_0003;

    localparam logic [CH_W-1:0] CH_SINE = 3'd0;
    localparam logic [CH_W-1:0] CH_SAW  = 3'd1;
    localparam logic [CH_W-1:0] CH_HELD = 3'd2;
    localparam logic [CH_W-1:0] CH_TRI  = 3'd3;
    localparam logic [CH_W-1:0] CH_SQR  = 3'd4;

    localparam logic REG_TRI_STEP = 1'b0;
    localparam logic REG_SEED     = 1'b1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CTRL,
        ST_SINE,
        ST_DLOAD,
        ST_DRUN,
        ST_EMIT
    } t_state;

    function automatic t_val sat_val(input logic signed [WIDE_W-1:0] v);
        logic in_range;
        in_range = (&v[WIDE_W-1:W-1]) || !(|v[WIDE_W-1:W-1]);
        if (in_range) begin
            sat_val = v[W-1:0];
        end else if (v[WIDE_W-1]) begin
            sat_val = VAL_MIN;
        end else begin
            sat_val = VAL_MAX;
        end
    endfunction

    function automatic t_val neg_sat(input t_val v);
        if (v == VAL_MIN) begin
            neg_sat = VAL_MAX;
        end else begin
            neg_sat = -v;
        end
    endfunction

endpackage

// File: hw/rtl/multi_wave_lfo_chunked_unit.sv
// Top level of the multi-wave low frequency oscillator with chunked control.
// Depends on mwlfo_pkg; holds the control step, the shared divider and the output stage.
//
// Each transfer on the slave stream is one control chunk; the block runs one control step
// and then sends chunk_length interpolated samples (clamped to 1..24), one per cycle while
// the master side accepts them. From its transfer to its last sample a chunk passes through
// the control step (ST_CTRL) and its multiplier (ST_SINE), then one shared restoring divider
// that runs once for each of the five interpolated channels (ST_DLOAD, ST_DRUN). The slave side
// is not ready from the transfer until the last sample is loaded into the output register.
module multi_wave_lfo_chunked_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwlfo_pkg::ADDR_W-1:0]        paddr,
    input  logic [mwlfo_pkg::DATA_W-1:0]        pwdata,
    output logic [mwlfo_pkg::DATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bit 0 reset_gate, bits 5:1 chunk_length, bits 7:6 zero.
    input  logic [mwlfo_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // From bit 0: sine_out, triangle_out, saw_up_out, saw_down_out, square_out,
    // held_out (18 bits each), then four zero bits.
    output logic [mwlfo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast
);
    import mwlfo_pkg::*;

    t_state                 r_state, n_state;
    logic [STEP_W-1:0]      r_tri_step;
    logic [SEED_W-1:0]      r_seed;
    logic [SEED_W-1:0]      r_lfsr;
    logic                   r_armed;
    t_val                   r_phase;
    t_val                   r_step;
    logic [1:0]             r_quad;
    t_val                   r_square;
    t_val                   r_saw;
    t_val                   r_sine;
    t_val                   r_held;
    t_val                   r_smooth [NCH];
    logic                   r_gate;
    logic [LEN_W-1:0]       r_len;
    logic signed [PROD_W-1:0] r_prod;
    logic [CH_W-1:0]        r_ch;
    logic [DIV_W-1:0]       r_dq;
    logic [LEN_W-1:0]       r_drem;
    logic [CNT_W-1:0]       r_dcnt;
    logic [DIV_W-1:0]       r_q0 [NCH];
    logic [LEN_W-1:0]       r_r0 [NCH];
    logic                   r_neg [NCH];
    logic [DIV_W-1:0]       r_acc_q [NCH];
    logic [LEN_W-1:0]       r_acc_r [NCH];
    logic [LEN_W-1:0]       r_frame;
    logic                   r_ovalid;
    logic                   r_olast;
    t_val                   r_out [NOUT];

    logic                   w_cfg_wr;
    logic                   w_accept;
    logic                   w_emit_load;
    logic                   w_div_last;
    logic                   w_frame_last;
    logic                   w_in_gate;
    logic [LEN_W-1:0]       w_in_len;
    logic [LEN_W-1:0]       w_len_clamped;

    // Control step.
    t_val                   w_dt0, w_dsa;
    logic                   w_restart;
    t_val                   w_ph0, w_st0, w_sq0, w_saw0;
    logic [1:0]             w_q0;
    t_val                   w_st1, w_sq1, w_saw1;
    logic [1:0]             w_q1;
    logic                   w_draw;
    logic [SEED_W-1:0]      w_lfsr_s, w_lfsr_nxt;
    t_val                   w_held_draw;
    logic signed [OPB_W-1:0] w_opb;
    logic signed [PROD_W-1:0] w_prod;
    t_val                   w_saw_new, w_phase_new, w_step_new;

    // Divider.
    t_val                   w_tgt [NCH];
    logic signed [W:0]      w_diff;
    logic [W:0]             w_mag;
    logic [LEN_W:0]         w_dtrial;
    logic                   w_dge;
    logic [LEN_W:0]         w_drem_n;

    // Interpolation lanes.
    logic [LEN_W:0]         w_rs [NCH];
    logic                   w_carry [NCH];
    logic [LEN_W-1:0]       w_acc_r_n [NCH];
    logic [DIV_W-1:0]       w_acc_q_n [NCH];
    t_val                   w_v [NCH];

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_SEED) ? r_seed : {{(DATA_W-STEP_W){1'b0}}, r_tri_step};

    // Input decode.
    assign w_in_gate = s_axis_tdata[0];
    assign w_in_len  = s_axis_tdata[LEN_W:1];
    always_comb begin
        if (w_in_len == '0) begin
            w_len_clamped = LEN_W'(1);
        end else if (w_in_len > LEN_W'(MAX_CHUNK)) begin
            w_len_clamped = LEN_W'(MAX_CHUNK);
        end else begin
            w_len_clamped = w_in_len;
        end
    end

    // Control step datapath.
    assign w_dt0     = t_val'({{(W-STEP_W){1'b0}}, r_tri_step});
    assign w_dsa     = t_val'({{(W-STEP_W+1){1'b0}}, r_tri_step[STEP_W-1:1]});
    assign w_restart = !r_armed && r_gate;
    assign w_ph0     = w_restart ? t_val'(0) : r_phase;
    assign w_q0      = w_restart ? QUAD_0 : r_quad;
    assign w_st0     = w_restart ? w_dt0 : r_step;
    assign w_sq0     = w_restart ? -VAL_ONE : r_square;
    assign w_saw0    = w_restart ? t_val'(0) : r_saw;

    assign w_lfsr_s   = (r_lfsr == '0) ? SEED_W'(1) : r_lfsr;
    assign w_lfsr_nxt = w_lfsr_s[0] ? ((w_lfsr_s >> 1) ^ LFSR_MASK) : (w_lfsr_s >> 1);
    assign w_held_draw = t_val'({1'b0, w_lfsr_nxt[SEED_W-1:SEED_W-F-1]}) - VAL_ONE;

    always_comb begin
        w_q1   = w_q0;
        w_st1  = w_st0;
        w_sq1  = w_sq0;
        w_saw1 = w_saw0;
        w_draw = 1'b0;
        if (w_ph0 >= VAL_ONE) begin
            w_q1  = QUAD_1;
            w_st1 = -w_dt0;
        end else if (w_ph0 <= -VAL_ONE) begin
            w_q1  = QUAD_3;
            w_st1 = w_dt0;
        end else if (w_q0 == QUAD_1 && w_ph0 < 0) begin
            w_q1   = QUAD_2;
            w_sq1  = VAL_ONE;
            w_draw = 1'b1;
        end else if (w_q0 == QUAD_3 && w_ph0 > 0) begin
            w_q1   = QUAD_0;
            w_sq1  = -VAL_ONE;
            w_draw = 1'b1;
            w_saw1 = -VAL_ONE;
        end
    end

    always_comb begin
        if (w_q1 == QUAD_0 || w_q1 == QUAD_1) begin
            w_opb = OPB_W'(VAL_ONE) + OPB_W'(VAL_ONE) - OPB_W'(w_ph0);
        end else begin
            w_opb = OPB_W'(VAL_ONE) + OPB_W'(VAL_ONE) + OPB_W'(w_ph0);
        end
    end
    assign w_prod      = PROD_W'(w_ph0) * PROD_W'(w_opb);
    assign w_saw_new   = sat_val(WIDE_W'(w_saw1) + WIDE_W'(w_dsa));
    assign w_phase_new = sat_val(WIDE_W'(w_ph0) + WIDE_W'(w_st1));
    assign w_step_new  = (w_q1 == QUAD_1 || w_q1 == QUAD_2) ? -w_dt0 : w_dt0;

    // Targets of the interpolation, in channel order.
    always_comb begin
        w_tgt[CH_SINE] = r_sine;
        w_tgt[CH_SAW]  = r_saw;
        w_tgt[CH_HELD] = r_held;
        w_tgt[CH_TRI]  = r_phase;
        w_tgt[CH_SQR]  = r_square;
    end

    // Shared divider: magnitude of the step over the chunk length.
    assign w_diff    = (W+1)'(w_tgt[r_ch]) - (W+1)'(r_smooth[r_ch]);
    assign w_mag     = w_diff[W] ? (W+1)'(-w_diff) : w_diff;
    assign w_dtrial  = {r_drem, r_dq[DIV_W-1]};
    assign w_dge     = w_dtrial >= {1'b0, r_len};
    assign w_drem_n  = w_dge ? (w_dtrial - {1'b0, r_len}) : w_dtrial;
    assign w_div_last = (r_dcnt == CNT_W'(DIV_W - 1));

    // Interpolation lanes.
    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            w_rs[j]      = {1'b0, r_acc_r[j]} + {1'b0, r_r0[j]};
            w_carry[j]   = w_rs[j] >= {1'b0, r_len};
            w_acc_r_n[j] = w_carry[j] ? LEN_W'(w_rs[j] - {1'b0, r_len}) : w_rs[j][LEN_W-1:0];
            w_acc_q_n[j] = r_acc_q[j] + r_q0[j] + DIV_W'(w_carry[j]);
            if (r_neg[j]) begin
                w_v[j] = t_val'((W+1)'(r_smooth[j]) - (W+1)'({1'b0, w_acc_q_n[j]}));
            end else begin
                w_v[j] = t_val'((W+1)'(r_smooth[j]) + (W+1)'({1'b0, w_acc_q_n[j]}));
            end
        end
    end

    assign w_frame_last = ((r_frame + LEN_W'(1)) == r_len);

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_CTRL;
                end
            end
            ST_CTRL:  n_state = ST_SINE;
            ST_SINE:  n_state = ST_DLOAD;
            ST_DLOAD: n_state = ST_DRUN;
            ST_DRUN: begin
                if (w_div_last) begin
                    n_state = (r_ch == CH_W'(NCH - 1)) ? ST_EMIT : ST_DLOAD;
                end
            end
            ST_EMIT: begin
                if (w_emit_load && w_frame_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_emit_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EMIT: w_emit_load   = !r_ovalid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                w_emit_load   = 1'b0;
            end
        endcase
    end
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration and oscillator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_step <= STEP_W'(655);
            r_seed     <= SEED_W'(1);
            r_lfsr     <= SEED_W'(1);
            r_armed    <= 1'b0;
            r_phase    <= '0;
            r_step     <= t_val'(655);
            r_quad     <= QUAD_0;
            r_square   <= '0;
            r_saw      <= -VAL_ONE;
            r_sine     <= '0;
            r_held     <= '0;
            for (int j = 0; j < NCH; j++) begin
                r_smooth[j] <= '0;
            end
        end else begin
            if (w_cfg_wr) begin
                if (paddr[2] == REG_SEED) begin
                    r_seed <= pwdata;
                    r_lfsr <= pwdata;
                end else begin
                    r_tri_step <= pwdata[STEP_W-1:0];
                end
            end else if (r_state == ST_CTRL && w_draw) begin
                r_lfsr <= w_lfsr_nxt;
            end
            if (r_state == ST_CTRL) begin
                r_armed  <= r_gate;
                r_quad   <= w_q1;
                r_square <= w_sq1;
                r_saw    <= w_saw_new;
                r_phase  <= w_phase_new;
                r_step   <= w_step_new;
                if (w_draw) begin
                    r_held <= w_held_draw;
                end
            end
            if (r_state == ST_SINE) begin
                r_sine <= sat_val(r_prod[PROD_W-1:F]);
            end
            if (w_emit_load && w_frame_last) begin
                for (int j = 0; j < NCH; j++) begin
                    r_smooth[j] <= w_tgt[j];
                end
            end
        end
    end

    // Chunk, divider and lane registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gate <= w_in_gate;
            r_len  <= w_len_clamped;
        end
        if (r_state == ST_CTRL) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_SINE) begin
            r_ch <= CH_SINE;
        end
        if (r_state == ST_DLOAD) begin
            r_dq         <= w_mag[DIV_W-1:0];
            r_drem       <= '0;
            r_dcnt       <= '0;
            r_neg[r_ch]  <= w_diff[W];
        end
        if (r_state == ST_DRUN) begin
            r_dq   <= {r_dq[DIV_W-2:0], w_dge};
            r_drem <= w_drem_n[LEN_W-1:0];
            r_dcnt <= r_dcnt + CNT_W'(1);
            if (w_div_last) begin
                r_q0[r_ch] <= {r_dq[DIV_W-2:0], w_dge};
                r_r0[r_ch] <= w_drem_n[LEN_W-1:0];
                r_ch       <= r_ch + CH_W'(1);
                r_frame    <= '0;
                for (int j = 0; j < NCH; j++) begin
                    r_acc_q[j] <= '0;
                    r_acc_r[j] <= '0;
                end
            end
        end
        if (w_emit_load) begin
            r_frame <= r_frame + LEN_W'(1);
            for (int j = 0; j < NCH; j++) begin
                r_acc_q[j] <= w_acc_q_n[j];
                r_acc_r[j] <= w_acc_r_n[j];
            end
            r_out[0] <= w_v[CH_SINE];
            r_out[1] <= w_v[CH_TRI];
            r_out[2] <= w_v[CH_SAW];
            r_out[3] <= neg_sat(w_v[CH_SAW]);
            r_out[4] <= neg_sat(w_v[CH_SQR]);
            r_out[5] <= w_v[CH_HELD];
            r_olast  <= w_frame_last;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {{(OUT_TDATA_W - NOUT*W){1'b0}},
                            r_out[5], r_out[4], r_out[3], r_out[2], r_out[1], r_out[0]};

endmodule

// File: hw/rtl/mwlfo_chk.sv
// Port-level checker for the multi-wave low frequency oscillator.
// Depends on mwlfo_pkg and is bound to multi_wave_lfo_chunked_unit at the end of this file.
module mwlfo_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [mwlfo_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                                m_axis_tlast
);
    import mwlfo_pkg::*;

    t_val w_saw_up;
    t_val w_saw_down;

    assign w_saw_up   = m_axis_tdata[3*W-1:2*W];
    assign w_saw_down = m_axis_tdata[4*W-1:3*W];

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("slave side ready in the cycle after a transfer");

    a_busy_mid_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("slave side ready while a chunk is still being sent");

    a_saw_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (((w_saw_up == VAL_MIN) && (w_saw_down == VAL_MAX)) ||
                           ((w_saw_up != VAL_MIN) && (w_saw_down == -w_saw_up))))
        else $error("falling saw is not the negated rising saw");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output transfer changed");

endmodule

bind multi_wave_lfo_chunked_unit mwlfo_chk u_mwlfo_chk (.*);

// File: bench/tb.sv
// Self-checking bench for the chunked multi-wave LFO: stream transfers in, predicted samples out.
// Depends on mwlfo_pkg and multi_wave_lfo_chunked_unit; registers are set over the APB port.
// A directed list of chunks runs first, then random chunks under several step and seed settings.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mwlfo_pkg::*;

    localparam longint ONE = longint'(1) << F;
    localparam longint HI = (longint'(1) << (F + 1)) - 1;
    localparam longint LO = -(longint'(1) << (F + 1));
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int DIRECTED_ROWS = 12;

    typedef struct packed {
        t_val sine;
        t_val triangle;
        t_val saw_up;
        t_val saw_down;
        t_val square;
        t_val held;
        logic last;
    } t_lfo_frame;

    typedef struct packed {
        logic       gate;
        logic [4:0] len;
        logic       typed;
        t_lfo_frame frame;
    } t_chunk_row;

    localparam t_lfo_frame NO_FRAME = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Bit 0 reset_gate, bits 5:1 chunk_length, bits 7:6 zero.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // From bit 0: sine_out, triangle_out, saw_up_out, saw_down_out, square_out,
    // held_out (18 bits each), then four zero bits.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    multi_wave_lfo_chunked_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    logic [STEP_W-1:0] step_reg = 16'd655;
    logic [SEED_W-1:0] seed_reg = 32'd1;
    logic              gate_armed_q = 1'b0;
    t_val              phase_q = '0;
    t_val              pstep_q = 18'sd655;
    logic [1:0]        quad_q = QUAD_0;
    t_val              square_q = '0;
    t_val              saw_q = -18'sd65536;
    t_val              sine_q = '0;
    t_val              held_q = '0;
    t_val              smooth_q [NCH] = '{default: '0};
    logic [SEED_W-1:0] lfsr_q = 32'd1;

    t_lfo_frame pending_frames [$];
    int         mismatch_count = 0;
    int         idle_cycles = 0;
    bit         idling_on = 1'b0;
    bit         hold_request = 1'b0;

    t_chunk_row directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, 5'd1,  1'b1, '{0, 655, -65209, 65209, 0, 0, 1'b1}},
        '{1'b1, 5'd1,  1'b1, '{0, 655, 327, -327, 65536, 0, 1'b1}},
        '{1'b1, 5'd16, 1'b0, NO_FRAME},
        '{1'b1, 5'd24, 1'b0, NO_FRAME},
        '{1'b0, 5'd0,  1'b0, NO_FRAME},
        '{1'b0, 5'd31, 1'b0, NO_FRAME},
        '{1'b1, 5'd25, 1'b0, NO_FRAME},
        '{1'b1, 5'd2,  1'b0, NO_FRAME},
        '{1'b0, 5'd16, 1'b0, NO_FRAME},
        '{1'b0, 5'd3,  1'b0, NO_FRAME},
        '{1'b1, 5'd16, 1'b0, NO_FRAME},
        '{1'b0, 5'd24, 1'b0, NO_FRAME}
    };

    function automatic t_val clamp_val(input longint v);
        if (v > HI) begin
            return t_val'(HI);
        end else if (v < LO) begin
            return t_val'(LO);
        end
        return t_val'(v);
    endfunction

    function automatic t_val draw_held();
        logic [SEED_W-1:0] s;
        s = (lfsr_q == '0) ? 32'd1 : lfsr_q;
        s = s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
        lfsr_q = s;
        return t_val'(longint'(s >> (31 - F)) - ONE);
    endfunction

    function automatic void check_field(input string label, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // One control step for an accepted chunk, then the interpolated frames it should produce.
    function automatic void advance_lfo(input logic gate, input logic [4:0] len_field);
        longint     dt0;
        longint     dsa;
        longint     factor;
        longint     k;
        longint     i;
        longint     goal [NCH];
        longint     start [NCH];
        longint     v [NCH];
        t_lfo_frame f;
        dt0 = step_reg;
        dsa = step_reg >> 1;
        k = len_field;
        if (k < 1) begin
            k = 1;
        end
        if (k > MAX_CHUNK) begin
            k = MAX_CHUNK;
        end

        if (!gate_armed_q && gate) begin
            gate_armed_q = 1'b1;
            phase_q = '0;
            quad_q = QUAD_0;
            pstep_q = t_val'(dt0);
            square_q = t_val'(-ONE);
            sine_q = '0;
            saw_q = '0;
        end else if (gate_armed_q && !gate) begin
            gate_armed_q = 1'b0;
        end

        if (phase_q >= ONE) begin
            quad_q = QUAD_1;
            pstep_q = t_val'(-dt0);
        end else if (phase_q <= -ONE) begin
            quad_q = QUAD_3;
            pstep_q = t_val'(dt0);
        end else if (quad_q == QUAD_1 && phase_q < 0) begin
            quad_q = QUAD_2;
            square_q = t_val'(ONE);
            held_q = draw_held();
        end else if (quad_q == QUAD_3 && phase_q > 0) begin
            quad_q = QUAD_0;
            square_q = t_val'(-ONE);
            held_q = draw_held();
            saw_q = t_val'(-ONE);
        end

        factor = (quad_q < QUAD_2) ? 2 * ONE - longint'(phase_q) : 2 * ONE + longint'(phase_q);
        sine_q = clamp_val((longint'(phase_q) * factor) >>> F);
        saw_q = clamp_val(longint'(saw_q) + dsa);
        phase_q = clamp_val(longint'(phase_q) + longint'(pstep_q));
        pstep_q = (quad_q == QUAD_1 || quad_q == QUAD_2) ? t_val'(-dt0) : t_val'(dt0);

        goal[CH_SINE] = sine_q;
        goal[CH_SAW] = saw_q;
        goal[CH_HELD] = held_q;
        goal[CH_TRI] = phase_q;
        goal[CH_SQR] = square_q;
        for (int j = 0; j < NCH; j++) begin
            start[j] = smooth_q[j];
        end
        for (i = 1; i <= k; i++) begin
            for (int j = 0; j < NCH; j++) begin
                v[j] = start[j] + ((goal[j] - start[j]) * i) / k;
            end
            f.sine = clamp_val(v[CH_SINE]);
            f.triangle = clamp_val(v[CH_TRI]);
            f.saw_up = clamp_val(v[CH_SAW]);
            f.saw_down = clamp_val(-v[CH_SAW]);
            f.square = clamp_val(-v[CH_SQR]);
            f.held = clamp_val(v[CH_HELD]);
            f.last = (i == k);
            pending_frames.push_back(f);
        end
        for (int j = 0; j < NCH; j++) begin
            smooth_q[j] = t_val'(goal[j]);
        end
    endfunction

    task automatic send_chunk(input logic gate, input logic [4:0] len);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, len, gate};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_lfo(gate, len);
    endtask

    // Write transfer, then a read-back of the same register.
    task automatic write_register(input logic reg_sel, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] stored;
        stored = (reg_sel == REG_TRI_STEP) ? {16'h0000, value[STEP_W-1:0]} : value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_sel == REG_TRI_STEP) begin
            step_reg = value[STEP_W-1:0];
        end else begin
            seed_reg = value;
            lfsr_q = value;
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field(reg_sel == REG_TRI_STEP ? "triangle_step read" : "random_seed read",
                    stored, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_lfo_frame seen;
        t_lfo_frame want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.sine = m_axis_tdata[0*W +: W];
            seen.triangle = m_axis_tdata[1*W +: W];
            seen.saw_up = m_axis_tdata[2*W +: W];
            seen.saw_down = m_axis_tdata[3*W +: W];
            seen.square = m_axis_tdata[4*W +: W];
            seen.held = m_axis_tdata[5*W +: W];
            seen.last = m_axis_tlast;
            if (pending_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: sample with none expected, expected nothing, got tdata %h",
                         $time, m_axis_tdata);
            end else begin
                want = pending_frames.pop_front();
                check_field("sine_out", want.sine, seen.sine);
                check_field("triangle_out", want.triangle, seen.triangle);
                check_field("saw_up_out", want.saw_up, seen.saw_up);
                check_field("saw_down_out", want.saw_down, seen.saw_down);
                check_field("square_out", want.square, seen.square);
                check_field("held_out", want.held, seen.held);
                check_field("last_frame", want.last, seen.last);
            end
        end
    end

    // The long hold lets the sender keep offering until the block stalls its input.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        logic [STEP_W-1:0] step_set [PHASES];
        logic [SEED_W-1:0] seed_set [PHASES];
        logic              gate;
        logic [4:0]        len;
        int                pick;
        step_set = '{16'd32768, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        seed_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        for (int s = 4; s < PHASES; s++) begin
            step_set[s] = 16'($urandom_range(1000, 32768));
        end
        for (int s = 3; s < PHASES; s++) begin
            seed_set[s] = $urandom() | 32'd1;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling_on = 1'b1;

        foreach (directed_rows[r]) begin
            send_chunk(directed_rows[r].gate, directed_rows[r].len);
            if (directed_rows[r].typed) begin
                void'(pending_frames.pop_back());
                pending_frames.push_back(directed_rows[r].frame);
            end
        end

        gate = 1'b0;
        for (int s = 0; s < PHASES; s++) begin
            s_axis_tvalid <= 1'b0;
            while (pending_frames.size() != 0) @(posedge i_clk);
            write_register(REG_TRI_STEP, {16'h0000, step_set[s]});
            write_register(REG_SEED, seed_set[s]);
            if (s == 1) begin
                hold_request = 1'b1;
            end
            if (s == PHASES - 1) begin
                idling_on = 1'b0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 11) == 0) begin
                    gate = ~gate;
                end
                pick = $urandom_range(0, 15);
                if (pick < 10) begin
                    len = 5'd16;
                end else if (pick < 14) begin
                    len = 5'($urandom_range(1, MAX_CHUNK));
                end else begin
                    len = 5'($urandom_range(0, 31));
                end
                send_chunk(gate, len);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: multi_wave_lfo_chunked_unit.f
hw/rtl/mwlfo_pkg.sv
hw/rtl/multi_wave_lfo_chunked_unit.sv
hw/rtl/mwlfo_chk.sv
bench/tb.sv
